[src/pgsg_pkg.sv]
package pgsg_pkg;

	localparam int unsigned DEF_WORDS_PER_REQUEST = 14;
	localparam int unsigned DEF_SKIP_WORDS = 50;
	localparam int unsigned DEF_QUEUE_DEPTH = 2;

	localparam int unsigned STATE_W = 31;
	localparam int unsigned WORD_W = 32;

	typedef logic [STATE_W-1:0] state_t;
	typedef logic [STATE_W-1:0][STATE_W-1:0] gf_mat_t;

	typedef enum logic [0:0] {
		REG_CELL_ID = 1'b0,
		REG_CP_MODE = 1'b1
	} reg_idx_t;

	typedef struct packed {
		logic [4:0] slot_index;
		logic       pilot_index;
	} req_t;

	typedef struct packed {
		logic [WORD_W-1:0] seq_word;
		logic [3:0]        word_index;
		logic              last_word;
	} res_t;

	// Bit i of a state holds x(n+i); one step shifts toward bit 0.
	function automatic state_t x1_adv(state_t s);
		return {s[0] ^ s[3], s[STATE_W-1:1]};
	endfunction

	function automatic state_t x2_adv(state_t s);
		return {s[0] ^ s[1] ^ s[2] ^ s[3], s[STATE_W-1:1]};
	endfunction

	// Column j holds the image of unit vector j after the given number of steps.
	function automatic gf_mat_t jump_mat(logic use_x2, int unsigned steps);
		gf_mat_t m;
		state_t s;
		for (int j = 0; j < STATE_W; j++) begin
			s = '0;
			s[j] = 1'b1;
			for (int unsigned n = 0; n < steps; n++) begin
				s = use_x2 ? x2_adv(s) : x1_adv(s);
			end
			m[j] = s;
		end
		return m;
	endfunction

	function automatic state_t mat_apply(gf_mat_t m, state_t v);
		state_t r;
		r = '0;
		for (int j = 0; j < STATE_W; j++) begin
			r = r ^ (m[j] & {STATE_W{v[j]}});
		end
		return r;
	endfunction

endpackage

[src/pgsg_queue.sv]
module pgsg_queue
	import pgsg_pkg::*;
#(
	parameter int unsigned DEPTH = DEF_QUEUE_DEPTH
) (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   push,
	output logic   full,
	input  state_t wdata,
	input  logic   pop,
	output logic   empty,
	output state_t rdata
);

	localparam int unsigned IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);

	state_t            ent_q [DEPTH];
	logic [IDX_W-1:0]  rd_ptr_q;
	logic [IDX_W-1:0]  wr_ptr_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              wr;
	logic              rd;

	assign full  = (cnt_q == CNT_W'(DEPTH));
	assign empty = (cnt_q == '0);
	assign wr    = push && !full;
	assign rd    = pop && !empty;
	assign rdata = ent_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_ptr_q <= '0;
			wr_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (wr) begin
				wr_ptr_q <= (wr_ptr_q == IDX_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (rd) begin
				rd_ptr_q <= (rd_ptr_q == IDX_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (wr && !rd) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (rd && !wr) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr) begin
			ent_q[wr_ptr_q] <= wdata;
		end
	end

endmodule

[src/pgsg_front.sv]
module pgsg_front
	import pgsg_pkg::*;
#(
	parameter int unsigned SKIP_WORDS = DEF_SKIP_WORDS
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	output logic       full,
	input  req_t       req,
	input  logic [8:0] cell_id,
	input  logic       cp_mode,
	output logic       q_push,
	input  logic       q_full,
	output state_t     q_data
);

	// x2 advanced over the discarded bits, as one linear map over GF(2).
	localparam gf_mat_t SkipX2 = jump_mat(1'b1, WORD_W * SKIP_WORDS);

	logic        valid_s1;
	state_t      seed_s1;
	logic        accept;
	logic [9:0]  two_c;
	logic [9:0]  fac_a;
	logic [7:0]  fac_b;
	logic [7:0]  k_term;
	logic [7:0]  slot_term;
	logic [17:0] prod;
	state_t      seed;

	assign full   = valid_s1 && q_full;
	assign accept = push && !full;
	assign q_push = valid_s1;
	assign q_data = mat_apply(SkipX2, seed_s1);

	always_comb begin
		two_c     = {cell_id, 1'b0};
		fac_a     = two_c + 10'd1;
		k_term    = req.pilot_index ? (cp_mode ? 8'd3 : 8'd4) : 8'd0;
		slot_term = 8'(({3'b000, req.slot_index} + 8'd1) * 8'd7);
		fac_b     = 8'd1 + k_term + slot_term;
		prod      = {8'd0, fac_a} * {10'd0, fac_b};
		seed      = STATE_W'(cp_mode) + STATE_W'(two_c) + {3'b000, prod, 10'b0};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (!q_full) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			seed_s1 <= seed;
		end
	end

endmodule

[src/pgsg_back.sv]
module pgsg_back
	import pgsg_pkg::*;
#(
	parameter int unsigned WORDS_PER_REQUEST = DEF_WORDS_PER_REQUEST,
	parameter int unsigned SKIP_WORDS = DEF_SKIP_WORDS
) (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   q_empty,
	output logic   q_pop,
	input  state_t q_data,
	output logic   empty,
	input  logic   pop,
	output res_t   res
);

	localparam int unsigned CNT_W = (WORDS_PER_REQUEST > 1) ? $clog2(WORDS_PER_REQUEST) : 1;
	localparam gf_mat_t StepX1 = jump_mat(1'b0, WORD_W);
	localparam gf_mat_t StepX2 = jump_mat(1'b1, WORD_W);
	localparam state_t X1Start = mat_apply(jump_mat(1'b0, WORD_W * SKIP_WORDS), STATE_W'(1));

	logic             active_q;
	logic [CNT_W-1:0] cnt_q;
	state_t           x1_q;
	state_t           x2_q;
	logic             out_valid_q;
	res_t             res_q;
	logic             adv;
	logic             gen;
	logic             last;
	logic             load;
	logic [WORD_W-1:0] word;

	assign adv   = !out_valid_q || pop;
	assign gen   = active_q && adv;
	assign last  = (cnt_q == CNT_W'(WORDS_PER_REQUEST - 1));
	// The next seed is taken in the cycle the last word is generated, so runs follow without a gap while a seed waits.
	assign load  = !q_empty && (!active_q || (gen && last));
	assign q_pop = load;
	assign empty = !out_valid_q;
	assign res   = res_q;

	// Bits 0..30 are the XOR of the two states; bit 31 is the XOR of their next feedback bits.
	assign word = {x1_q[0] ^ x1_q[3] ^ x2_q[0] ^ x2_q[1] ^ x2_q[2] ^ x2_q[3], x1_q ^ x2_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q    <= 1'b0;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				active_q <= 1'b1;
				cnt_q    <= '0;
			end else if (gen) begin
				cnt_q <= cnt_q + 1'b1;
				if (last) begin
					active_q <= 1'b0;
				end
			end
			if (adv) begin
				out_valid_q <= gen;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			x1_q <= X1Start;
			x2_q <= q_data;
		end else if (gen) begin
			x1_q <= mat_apply(StepX1, x1_q);
			x2_q <= mat_apply(StepX2, x2_q);
		end
		if (gen) begin
			res_q.seq_word   <= word;
			res_q.word_index <= 4'(cnt_q);
			res_q.last_word  <= last;
		end
	end

endmodule

[src/pilot_gold_sequence_generator.sv]
// Channel   Direction  Handshake             Payload
// request   in         push / full           req (slot_index, pilot_index)
// result    out        pop / empty           res (seq_word, word_index, last_word)
// config    in         cfg_we, cfg_idx       cfg_wdata (cell_id, cp_mode)
//
// Each request yields WORDS_PER_REQUEST words (14 by default), one per cycle while pops keep up;
// the back end steps both shift registers by 32 bits per word. The first word passes the front
// end's seed register, the seed queue and the back end's state registers to reach the output register.
// Reset is asynchronous; it clears the control registers and empties the queue; no clearing pass is needed.
// A stalled pop holds the generator, and push stalls once the seed queue is full and the front end holds a seed.
module pilot_gold_sequence_generator
	import pgsg_pkg::*;
#(
	parameter int unsigned WORDS_PER_REQUEST = DEF_WORDS_PER_REQUEST,
	parameter int unsigned SKIP_WORDS = DEF_SKIP_WORDS,
	parameter int unsigned QUEUE_DEPTH = DEF_QUEUE_DEPTH
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	output logic       full,
	input  req_t       req,
	output logic       empty,
	input  logic       pop,
	output res_t       res,
	input  logic       cfg_we,
	input  logic [0:0] cfg_idx,
	input  logic [8:0] cfg_wdata
);

	logic [8:0] cell_id_q;
	logic       cp_mode_q;
	logic       q_push;
	logic       q_full;
	state_t     q_wdata;
	logic       q_pop;
	logic       q_empty;
	state_t     q_rdata;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cell_id_q <= '0;
			cp_mode_q <= 1'b0;
		end else if (cfg_we) begin
			case (reg_idx_t'(cfg_idx))
				REG_CELL_ID: cell_id_q <= cfg_wdata;
				REG_CP_MODE: cp_mode_q <= cfg_wdata[0];
				default: ;
			endcase
		end
	end

	pgsg_front #(
		.SKIP_WORDS(SKIP_WORDS)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.req(req),
		.cell_id(cell_id_q),
		.cp_mode(cp_mode_q),
		.q_push(q_push),
		.q_full(q_full),
		.q_data(q_wdata)
	);

	pgsg_queue #(
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(q_push),
		.full(q_full),
		.wdata(q_wdata),
		.pop(q_pop),
		.empty(q_empty),
		.rdata(q_rdata)
	);

	pgsg_back #(
		.WORDS_PER_REQUEST(WORDS_PER_REQUEST),
		.SKIP_WORDS(SKIP_WORDS)
	) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.q_empty(q_empty),
		.q_pop(q_pop),
		.q_data(q_rdata),
		.empty(empty),
		.pop(pop),
		.res(res)
	);

	// The front end only holds off a request while the seed queue is full.
	a_full_needs_queue_full: assert property (@(posedge clk) disable iff (!arst_n)
		full |-> q_full)
		else $error("front end stalled with room in the seed queue");

	// Within a run the next word follows at once with the next index.
	a_run_continues: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && !empty && !res.last_word) |=>
			(!empty && res.word_index == $past(res.word_index) + 4'd1))
		else $error("run broken or word index skipped");

	a_last_index: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && res.last_word) |-> (res.word_index == 4'(WORDS_PER_REQUEST - 1)))
		else $error("last word flagged at wrong index");

endmodule
